[rtl/azq_pkg.sv]
// ----------------------------------------------------------------------------
// azq_pkg: shared types and constants for the alarm zone input qualifier
// Field widths, command and status codes, register indexes, reset values,
// the per-zone record kept in the zone memory and the configuration bundle.
// ----------------------------------------------------------------------------
package azq_pkg;

  localparam int ZONES_DEF  = 16;
  localparam int CMD_W      = 2;
  localparam int TS_W       = 32;
  localparam int LVL_W      = 16;
  localparam int ZONE_W     = 4;
  localparam int STATE_W    = 2;
  localparam int DEB_W      = 16;
  localparam int VTO_W      = 20;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NC_WIRING = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VIRT_TMO  = 8'd3;

  // Register reset values
  localparam logic [LVL_W-1:0] RST_ENABLED   = 16'hFFFF;
  localparam logic [LVL_W-1:0] RST_NC_WIRING = 16'h0000;
  localparam logic [DEB_W-1:0] RST_DEBOUNCE  = 16'd50;
  localparam logic [VTO_W-1:0] RST_VIRT_TMO  = 20'd30000;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_SCAN   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_VIRT   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_BYPASS = 2'd2;

  // Result word kinds
  localparam logic KIND_EVENT   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Zone state codes
  typedef enum logic [STATE_W-1:0] {
    ST_NORMAL    = 2'd0,
    ST_TRIGGERED = 2'd1,
    ST_TAMPER    = 2'd2,
    ST_BYPASSED  = 2'd3
  } zstat_e;

  // Per-zone record held in the zone memory
  typedef struct packed {
    logic            settled;
    logic            deb_act;
    logic            pending;
    logic [TS_W-1:0] deb_start;
    logic            virt_act;
    logic [TS_W-1:0] virt_start;
  } zrec_t;

  // Configuration registers as seen by the sequencer
  typedef struct packed {
    logic [LVL_W-1:0] enabled_mask;
    logic [LVL_W-1:0] nc_wiring_mask;
    logic [DEB_W-1:0] debounce_ms;
    logic [VTO_W-1:0] virtual_timeout_ms;
  } cfg_t;

endpackage

[rtl/azq_in_if.sv]
// ----------------------------------------------------------------------------
// azq_in_if: command channel
// Valid/ready channel carrying one command word per handshake.
// ----------------------------------------------------------------------------
interface azq_in_if;
  logic                       valid;
  logic                       ready;
  logic [azq_pkg::CMD_W-1:0]  command;
  logic [azq_pkg::TS_W-1:0]   now_ms;
  logic [azq_pkg::LVL_W-1:0]  input_levels;
  logic                       tamper;
  logic [azq_pkg::ZONE_W-1:0] zone;
  logic                       level;

  modport source (output valid, command, now_ms, input_levels, tamper, zone, level,
                  input ready);
  modport sink   (input valid, command, now_ms, input_levels, tamper, zone, level,
                  output ready);
endinterface

[rtl/azq_out_if.sv]
// ----------------------------------------------------------------------------
// azq_out_if: result channel
// Valid/ready channel carrying event and summary words.
// ----------------------------------------------------------------------------
interface azq_out_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [azq_pkg::ZONE_W-1:0]  event_zone;
  logic [azq_pkg::STATE_W-1:0] new_state;
  logic [azq_pkg::LVL_W-1:0]   triggered_mask;
  logic                        all_clear;
  logic                        last;

  modport source (output valid, kind, event_zone, new_state, triggered_mask, all_clear,
                  last, input ready);
  modport sink   (input valid, kind, event_zone, new_state, triggered_mask, all_clear,
                  last, output ready);
endinterface

[rtl/azq_cfg_if.sv]
// ----------------------------------------------------------------------------
// azq_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface azq_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [azq_pkg::CFG_IDX_W-1:0]  index;
  logic [azq_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/azq_cfg.sv]
// ----------------------------------------------------------------------------
// azq_cfg: configuration register file
// Holds the zone masks, debounce time and virtual input timeout.
// ----------------------------------------------------------------------------
module azq_cfg (
  input  logic            clk_i,
  input  logic            rst_ni,
  azq_cfg_if.sink         cfg_ch,
  output azq_pkg::cfg_t   cfg_o
);

  azq_pkg::cfg_t cfg_q;

  // Take every write word at once
  assign cfg_ch.ready = 1'b1;
  assign cfg_o        = cfg_q;

  // Update the addressed register, drop writes beyond the list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enabled_mask       <= azq_pkg::RST_ENABLED;
      cfg_q.nc_wiring_mask     <= azq_pkg::RST_NC_WIRING;
      cfg_q.debounce_ms        <= azq_pkg::RST_DEBOUNCE;
      cfg_q.virtual_timeout_ms <= azq_pkg::RST_VIRT_TMO;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        azq_pkg::CFG_ENABLED: begin
          cfg_q.enabled_mask <= cfg_ch.data[azq_pkg::LVL_W-1:0];
        end
        azq_pkg::CFG_NC_WIRING: begin
          cfg_q.nc_wiring_mask <= cfg_ch.data[azq_pkg::LVL_W-1:0];
        end
        azq_pkg::CFG_DEBOUNCE: begin
          cfg_q.debounce_ms <= cfg_ch.data[azq_pkg::DEB_W-1:0];
        end
        azq_pkg::CFG_VIRT_TMO: begin
          cfg_q.virtual_timeout_ms <= cfg_ch.data[azq_pkg::VTO_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[rtl/azq_zone_mem.sv]
// ----------------------------------------------------------------------------
// azq_zone_mem: per-zone record memory
// One write and one read port, registered read data, a valid bit per entry
// so that an entry not yet written reads as its reset record.
// ----------------------------------------------------------------------------
module azq_zone_mem #(
  parameter int ZONES = azq_pkg::ZONES_DEF,
  parameter int IW    = (ZONES > 1) ? $clog2(ZONES) : 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           re_i,
  input  logic [IW-1:0]  raddr_i,
  input  logic           we_i,
  input  logic [IW-1:0]  waddr_i,
  input  azq_pkg::zrec_t wdata_i,
  output azq_pkg::zrec_t rdata_o
);

  azq_pkg::zrec_t mem [ZONES];
  azq_pkg::zrec_t rdata_q;
  logic [ZONES-1:0] vld_q;
  logic             rvld_q;

  // Storage array, no reset
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  // Track written entries and the valid flag of the read word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvld_q <= vld_q[raddr_i];
      end
    end
  end

  // Unwritten entry reads as the all-zero reset record
  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

[rtl/azq_seq.sv]
// ----------------------------------------------------------------------------
// azq_seq: command sequencer
// Walks the zone records through read, modify and write back, holds the
// zone states, and drives the output register with events and summaries.
// ----------------------------------------------------------------------------
module azq_seq #(
  parameter int ZONES = azq_pkg::ZONES_DEF,
  parameter int IW    = (ZONES > 1) ? $clog2(ZONES) : 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  azq_in_if.sink         in_ch,
  azq_out_if.source      out_ch,
  input  azq_pkg::cfg_t  cfg_i,
  output logic           mem_re_o,
  output logic [IW-1:0]  mem_raddr_o,
  output logic           mem_we_o,
  output logic [IW-1:0]  mem_waddr_o,
  output azq_pkg::zrec_t mem_wdata_o,
  input  azq_pkg::zrec_t mem_rdata_i
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_ZONE = 4'b0100,
    S_SUM  = 4'b1000
  } seq_state_e;

  seq_state_e state_q, state_d;
  logic [IW-1:0] idx_q, idx_d;

  logic [azq_pkg::CMD_W-1:0]  cmd_q;
  logic [azq_pkg::TS_W-1:0]   now_q;
  logic [azq_pkg::LVL_W-1:0]  lvls_q;
  logic                       tamper_q;
  logic                       level_q;

  azq_pkg::zstat_e status_q [ZONES];

  logic                        out_vld_q;
  logic                        out_kind_q;
  logic [azq_pkg::ZONE_W-1:0]  out_zone_q;
  logic [azq_pkg::STATE_W-1:0] out_state_q;
  logic [azq_pkg::LVL_W-1:0]   out_mask_q;
  logic                        out_clear_q;
  logic                        out_last_q;

  logic            in_fire, out_free, in_zone_ok;
  logic            idx_last;
  azq_pkg::zrec_t  rec, nrec;
  azq_pkg::zstat_e cur_st, nst;
  logic            scanned, ev_need;
  logic            raw, va, trig;
  logic [azq_pkg::TS_W-1:0] vdiff, ddiff;
  logic            st_we, emit_ev, emit_sum;
  logic [ZONES-1:0] tmask;
  logic            clear;

  assign in_fire    = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_q == S_IDLE);
  assign out_free   = !out_vld_q || out_ch.ready;
  assign in_zone_ok = (32'(in_ch.zone) < ZONES);
  assign idx_last   = (idx_q == IW'(ZONES - 1));

  assign rec    = mem_rdata_i;
  assign cur_st = status_q[idx_q];
  assign vdiff  = now_q - rec.virt_start;
  assign ddiff  = now_q - rec.deb_start;

  // Modify the record of the current zone
  always_comb begin
    nrec    = rec;
    nst     = cur_st;
    scanned = 1'b0;
    va      = 1'b0;
    raw     = 1'b0;
    trig    = 1'b0;
    case (cmd_q)
      azq_pkg::CMD_SCAN: begin
        scanned = cfg_i.enabled_mask[idx_q] && (cur_st != azq_pkg::ST_BYPASSED);
        // expire a stale virtual input
        va   = rec.virt_act && !(vdiff >= 32'(cfg_i.virtual_timeout_ms));
        raw  = lvls_q[idx_q] ^ cfg_i.nc_wiring_mask[idx_q];
        trig = raw || va;
        nrec.virt_act = va;
        if (tamper_q) begin
          nrec.settled = 1'b1;
          nrec.deb_act = 1'b0;
          nst          = azq_pkg::ST_TAMPER;
        end else if (trig != rec.settled) begin
          if (!rec.deb_act) begin
            nrec.deb_act   = 1'b1;
            nrec.deb_start = now_q;
            nrec.pending   = trig;
          end else if (trig != rec.pending) begin
            nrec.deb_start = now_q;
            nrec.pending   = trig;
          end else if (ddiff >= 32'(cfg_i.debounce_ms)) begin
            nrec.settled = trig;
            nrec.deb_act = 1'b0;
            nst = trig ? azq_pkg::ST_TRIGGERED : azq_pkg::ST_NORMAL;
          end
        end else begin
          nrec.deb_act = 1'b0;
        end
      end
      azq_pkg::CMD_VIRT: begin
        nrec.virt_act = level_q;
        if (level_q) begin
          nrec.virt_start = now_q;
        end
      end
      azq_pkg::CMD_BYPASS: begin
        if (level_q) begin
          nst = azq_pkg::ST_BYPASSED;
        end else begin
          nst          = azq_pkg::ST_NORMAL;
          nrec.settled = 1'b0;
          nrec.deb_act = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  assign ev_need = scanned && (nst != cur_st);

  // Sequence the read, modify, write back and result words
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = idx_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = idx_q;
    mem_wdata_o = nrec;
    st_we       = 1'b0;
    emit_ev     = 1'b0;
    emit_sum    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (in_ch.command == azq_pkg::CMD_SCAN) begin
            idx_d   = '0;
            state_d = S_READ;
          end else if ((in_ch.command == azq_pkg::CMD_VIRT ||
                        in_ch.command == azq_pkg::CMD_BYPASS) && in_zone_ok) begin
            idx_d   = in_ch.zone[IW-1:0];
            state_d = S_READ;
          end else begin
            state_d = S_SUM;
          end
        end
      end
      S_READ: begin
        mem_re_o = 1'b1;
        state_d  = S_ZONE;
      end
      S_ZONE: begin
        if (cmd_q == azq_pkg::CMD_SCAN) begin
          // hold while an event waits for a free output register
          if (!ev_need || out_free) begin
            mem_we_o = scanned;
            st_we    = scanned;
            emit_ev  = ev_need;
            if (idx_last) begin
              state_d = S_SUM;
            end else begin
              idx_d       = idx_q + IW'(1);
              mem_re_o    = 1'b1;
              mem_raddr_o = idx_q + IW'(1);
            end
          end
        end else begin
          mem_we_o = 1'b1;
          st_we    = (cmd_q == azq_pkg::CMD_BYPASS);
          state_d  = S_SUM;
        end
      end
      S_SUM: begin
        if (out_free) begin
          emit_sum = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Gather the summary over all zone states
  always_comb begin
    clear = 1'b1;
    for (int i = 0; i < ZONES; i++) begin
      tmask[i] = (status_q[i] == azq_pkg::ST_TRIGGERED);
      if (cfg_i.enabled_mask[i] && status_q[i] != azq_pkg::ST_BYPASSED &&
          status_q[i] != azq_pkg::ST_NORMAL) begin
        clear = 1'b0;
      end
    end
  end

  // Control registers and zone states
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      for (int i = 0; i < ZONES; i++) begin
        status_q[i] <= azq_pkg::ST_NORMAL;
      end
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (st_we) begin
        status_q[idx_q] <= nst;
      end
    end
  end

  // Capture the command word
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q    <= in_ch.command;
      now_q    <= in_ch.now_ms;
      lvls_q   <= in_ch.input_levels;
      tamper_q <= in_ch.tamper;
      level_q  <= in_ch.level;
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (emit_ev || emit_sum) begin
      out_vld_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (emit_ev) begin
      out_kind_q  <= azq_pkg::KIND_EVENT;
      out_zone_q  <= azq_pkg::ZONE_W'(idx_q);
      out_state_q <= nst;
      out_mask_q  <= '0;
      out_clear_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else if (emit_sum) begin
      out_kind_q  <= azq_pkg::KIND_SUMMARY;
      out_zone_q  <= '0;
      out_state_q <= '0;
      out_mask_q  <= azq_pkg::LVL_W'(tmask);
      out_clear_q <= clear;
      out_last_q  <= 1'b1;
    end
  end

  assign out_ch.valid          = out_vld_q;
  assign out_ch.kind           = out_kind_q;
  assign out_ch.event_zone     = out_zone_q;
  assign out_ch.new_state      = out_state_q;
  assign out_ch.triggered_mask = out_mask_q;
  assign out_ch.all_clear      = out_clear_q;
  assign out_ch.last           = out_last_q;

  // A word replacing a waiting one would be lost
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_ch.ready) |-> !(emit_ev || emit_sum))
    else $error("output word overwritten while stalled");

  // A command never returns to idle without its summary
  a_sum_before_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE && state_d == S_IDLE) |-> emit_sum)
    else $error("command closed without summary");

  // Record writes only happen while a zone word is held
  a_write_in_zone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> (state_q == S_ZONE))
    else $error("zone record written outside zone step");

  // Read of the next zone never targets the entry being written
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we_o && mem_re_o) |-> (mem_raddr_o != mem_waddr_o))
    else $error("read and write of the same zone record");

endmodule

[rtl/alarm_zone_input_qualifier.sv]
// ----------------------------------------------------------------------------
// alarm_zone_input_qualifier: multi-zone alarm input debouncer
// Scans the zone inputs against per-zone records, debounces, expires virtual
// inputs, applies tamper and bypass, and reports state changes and summaries.
//
//   channel  dir  handshake     word
//   in_ch    in   valid/ready   command, now_ms, input_levels, tamper, zone, level
//   out_ch   out  valid/ready   kind, event_zone, new_state, triggered_mask,
//                               all_clear, last
//   cfg_ch   in   valid/ready   index, data (always ready)
//
// A scan reads the first record, then takes one zone per cycle through the read
// port and the write port of the zone memory, then loads the summary; an event
// or the summary waits while the output register holds a word not yet taken.
// A set command reads and writes back its zone record, then loads the summary;
// an out-of-range zone or unknown command goes straight to the summary. A new
// command is taken in the cycle after the summary is loaded. Reset loads the
// register reset values and clears zone states and record valid bits at once.
// An output stall holds the sequencer at the pending event's zone or the summary.
// ----------------------------------------------------------------------------
module alarm_zone_input_qualifier #(
  parameter int ZONES = azq_pkg::ZONES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  azq_in_if.sink    in_ch,
  azq_out_if.source out_ch,
  azq_cfg_if.sink   cfg_ch
);

  localparam int IW = (ZONES > 1) ? $clog2(ZONES) : 1;

  azq_pkg::cfg_t  cfg;
  logic           mem_re;
  logic [IW-1:0]  mem_raddr;
  logic           mem_we;
  logic [IW-1:0]  mem_waddr;
  azq_pkg::zrec_t mem_wdata;
  azq_pkg::zrec_t mem_rdata;

  // Configuration registers
  azq_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_ch (cfg_ch),
    .cfg_o  (cfg)
  );

  // Zone record memory
  azq_zone_mem #(
    .ZONES (ZONES),
    .IW    (IW)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // Command sequencer and output register
  azq_seq #(
    .ZONES (ZONES),
    .IW    (IW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_i       (cfg),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

endmodule

[sim/alarm_zone_input_qualifier_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// alarm_zone_input_qualifier_test: self-checking bench for the zone qualifier
// A short table of directed commands walks through debounce, tamper,
// bypass, virtual expiry, an unknown command and a timestamp wrap. Random
// phases then follow under several register settings, extremes included.
// An in-bench copy of the zone logic predicts every event and summary word.
// Each word on the result channel is compared against the oldest prediction.
// Both channels idle at random, and the receiver stalls once for a long time.
// ----------------------------------------------------------------------------
module alarm_zone_input_qualifier_test;

  localparam int ZONES         = azq_pkg::ZONES_DEF;
  localparam int NUM_DIRECTED  = 25;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD     = 300;
  localparam int MAX_REPORTS   = 10;

  // Command code the block treats as a no-op
  localparam logic [azq_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [azq_pkg::CMD_W-1:0]  cmd;
    logic [azq_pkg::TS_W-1:0]   now;
    logic [azq_pkg::LVL_W-1:0]  levels;
    logic                       tamper;
    logic [azq_pkg::ZONE_W-1:0] zone;
    logic                       level;
  } zone_cmd_t;

  typedef struct packed {
    logic                       kind;
    logic [azq_pkg::ZONE_W-1:0] zone;
    azq_pkg::zstat_e            state;
    logic [azq_pkg::LVL_W-1:0]  trig_mask;
    logic                       all_clear;
    logic                       last;
  } azq_word_t;

  // Directed row; summary typed in where it is obvious and no event occurs
  typedef struct packed {
    logic [azq_pkg::CMD_W-1:0]  cmd;
    logic [azq_pkg::TS_W-1:0]   now;
    logic [azq_pkg::LVL_W-1:0]  levels;
    logic                       tamper;
    logic [azq_pkg::ZONE_W-1:0] zone;
    logic                       level;
    logic                       known;
    logic [azq_pkg::LVL_W-1:0]  known_mask;
    logic                       known_clear;
  } dir_row_t;

  dir_row_t directed_rows [NUM_DIRECTED] = '{
    // quiet scan after reset, then all zones high: debounce starts
    '{azq_pkg::CMD_SCAN,   32'd0,   16'h0000, 1'b0, 4'd0, 1'b0, 1'b1, 16'h0000, 1'b1},
    '{azq_pkg::CMD_SCAN,   32'd10,  16'hFFFF, 1'b0, 4'd0, 1'b0, 1'b1, 16'h0000, 1'b1},
    '{azq_pkg::CMD_SCAN,   32'd30,  16'hFFFF, 1'b0, 4'd0, 1'b0, 1'b1, 16'h0000, 1'b1},
    // debounce time reached: every zone triggers
    '{azq_pkg::CMD_SCAN,   32'd60,  16'hFFFF, 1'b0, 4'd0, 1'b0, 1'b0, 16'h0000, 1'b0},
    // drop, then half back high (cancel), half accepted as normal
    '{azq_pkg::CMD_SCAN,   32'd70,  16'h0000, 1'b0, 4'd0, 1'b0, 1'b1, 16'hFFFF, 1'b0},
    '{azq_pkg::CMD_SCAN,   32'd80,  16'h00FF, 1'b0, 4'd0, 1'b0, 1'b1, 16'hFFFF, 1'b0},
    '{azq_pkg::CMD_SCAN,   32'd130, 16'h00FF, 1'b0, 4'd0, 1'b0, 1'b0, 16'h0000, 1'b0},
    // tamper forces every zone, then recovery through debounce
    '{azq_pkg::CMD_SCAN,   32'd140, 16'h0000, 1'b1, 4'd0, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{azq_pkg::CMD_SCAN,   32'd150, 16'h0000, 1'b0, 4'd0, 1'b0, 1'b1, 16'h0000, 1'b0},
    '{azq_pkg::CMD_SCAN,   32'd200, 16'h0000, 1'b0, 4'd0, 1'b0, 1'b0, 16'h0000, 1'b0},
    // virtual input on zone 3 triggers it
    '{azq_pkg::CMD_VIRT,   32'd210, 16'h0000, 1'b0, 4'd3, 1'b1, 1'b1, 16'h0000, 1'b1},
    '{azq_pkg::CMD_SCAN,   32'd220, 16'h0000, 1'b0, 4'd0, 1'b0, 1'b1, 16'h0000, 1'b1},
    '{azq_pkg::CMD_SCAN,   32'd270, 16'h0000, 1'b0, 4'd0, 1'b0, 1'b0, 16'h0000, 1'b0},
    // bypass on and off, no events from either
    '{azq_pkg::CMD_BYPASS, 32'd280, 16'h0000, 1'b0, 4'd3, 1'b1, 1'b1, 16'h0000, 1'b1},
    '{azq_pkg::CMD_SCAN,   32'd290, 16'h8000, 1'b0, 4'd0, 1'b0, 1'b1, 16'h0000, 1'b1},
    '{azq_pkg::CMD_BYPASS, 32'd300, 16'h0000, 1'b0, 4'd3, 1'b0, 1'b1, 16'h0000, 1'b1},
    // virtual input on zone 3 has expired by now
    '{azq_pkg::CMD_SCAN, 32'd30300, 16'h0000, 1'b0, 4'd0,  1'b0, 1'b1, 16'h0000, 1'b1},
    '{azq_pkg::CMD_VIRT, 32'd30310, 16'h0000, 1'b0, 4'd15, 1'b1, 1'b1, 16'h0000, 1'b1},
    '{azq_pkg::CMD_VIRT, 32'd30320, 16'h0000, 1'b0, 4'd15, 1'b0, 1'b1, 16'h0000, 1'b1},
    // unknown command changes nothing
    '{CMD_UNUSED, 32'hA5A5_5A5A, 16'hFFFF, 1'b1, 4'd15, 1'b1, 1'b1, 16'h0000, 1'b1},
    // debounce across the timestamp wrap
    '{azq_pkg::CMD_SCAN, 32'hFFFF_FFF0, 16'hFFFF, 1'b0, 4'd0, 1'b0, 1'b1, 16'h0000, 1'b1},
    '{azq_pkg::CMD_SCAN, 32'h0000_0030, 16'hFFFF, 1'b0, 4'd0, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{azq_pkg::CMD_SCAN, 32'h0000_0040, 16'hFFFF, 1'b1, 4'd0, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{azq_pkg::CMD_BYPASS, 32'h0000_0050, 16'h0000, 1'b0, 4'd0, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{azq_pkg::CMD_BYPASS, 32'h0000_0060, 16'h0000, 1'b0, 4'd0, 1'b0, 1'b0, 16'h0000, 1'b0}
  };

  logic clk_i;
  logic rst_ni;

  azq_in_if  in_bus ();
  azq_out_if out_bus ();
  azq_cfg_if cfg_bus ();

  alarm_zone_input_qualifier u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  // Register shadow
  logic [azq_pkg::LVL_W-1:0] cfg_enabled;
  logic [azq_pkg::LVL_W-1:0] cfg_nc;
  logic [azq_pkg::DEB_W-1:0] cfg_debounce;
  logic [azq_pkg::VTO_W-1:0] cfg_virt_tmo;

  // Zone state shadow
  azq_pkg::zstat_e          zone_state [ZONES];
  logic [ZONES-1:0]         settled_lvl;
  logic [ZONES-1:0]         deb_busy;
  logic [ZONES-1:0]         deb_target;
  logic [ZONES-1:0]         virt_on;
  logic [azq_pkg::TS_W-1:0] deb_since  [ZONES];
  logic [azq_pkg::TS_W-1:0] virt_since [ZONES];

  azq_word_t expected_words [$];

  int          error_count;
  int          cycle_count;
  int          commands_sent;
  int          events_seen;
  int          summaries_seen;
  int          settings_used;
  int          send_gap;
  int          sink_hold;
  bit          no_idle;
  logic [31:0] wall_ms;
  logic [15:0] loop_levels;
  azq_word_t   want;
  azq_word_t   got;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop on a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("alarm_zone_input_qualifier_test: timeout after %0d cycles", cycle_count);
      $display("alarm_zone_input_qualifier_test: done, errors");
      $finish;
    end
  end

  // Print the first few mismatches, count the rest
  task automatic flag_error(string what, azq_word_t exp_w, azq_word_t act_w);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("%s: exp kind=%0d zone=%0d state=%0d mask=%h clear=%0d last=%0d",
               what, exp_w.kind, exp_w.zone, exp_w.state, exp_w.trig_mask,
               exp_w.all_clear, exp_w.last);
      $display("%s: got kind=%0d zone=%0d state=%0d mask=%h clear=%0d last=%0d",
               what, act_w.kind, act_w.zone, act_w.state, act_w.trig_mask,
               act_w.all_clear, act_w.last);
    end
  endtask

  function automatic void clear_model();
    cfg_enabled  = azq_pkg::RST_ENABLED;
    cfg_nc       = azq_pkg::RST_NC_WIRING;
    cfg_debounce = azq_pkg::RST_DEBOUNCE;
    cfg_virt_tmo = azq_pkg::RST_VIRT_TMO;
    settled_lvl  = '0;
    deb_busy     = '0;
    deb_target   = '0;
    virt_on      = '0;
    for (int i = 0; i < ZONES; i++) begin
      zone_state[i] = azq_pkg::ST_NORMAL;
      deb_since[i]  = '0;
      virt_since[i] = '0;
    end
  endfunction

  // Move a zone to a new state; only a real change produces an event word
  function automatic void note_state(int z, azq_pkg::zstat_e st);
    azq_word_t w;
    if (zone_state[z] == st) return;
    zone_state[z] = st;
    w       = '0;
    w.kind  = azq_pkg::KIND_EVENT;
    w.zone  = z[azq_pkg::ZONE_W-1:0];
    w.state = st;
    expected_words.push_back(w);
  endfunction

  // Apply one command to the shadow and queue the words it must produce
  function automatic void qualify_command(zone_cmd_t c);
    logic      raw;
    logic      trig;
    azq_word_t w;
    w = '0;
    case (c.cmd)
      azq_pkg::CMD_SCAN: begin
        for (int i = 0; i < ZONES; i++) begin
          if (cfg_enabled[i] && zone_state[i] != azq_pkg::ST_BYPASSED) begin
            // expire a stale virtual input first
            if (virt_on[i] && (c.now - virt_since[i]) >= 32'(cfg_virt_tmo))
              virt_on[i] = 1'b0;
            raw  = c.levels[i] ^ cfg_nc[i];
            trig = raw | virt_on[i];
            if (c.tamper) begin
              settled_lvl[i] = 1'b1;
              deb_busy[i]    = 1'b0;
              note_state(i, azq_pkg::ST_TAMPER);
            end else if (trig != settled_lvl[i]) begin
              if (!deb_busy[i]) begin
                deb_busy[i]   = 1'b1;
                deb_since[i]  = c.now;
                deb_target[i] = trig;
              end else if (trig != deb_target[i]) begin
                // pending level moved: restart the debounce
                deb_since[i]  = c.now;
                deb_target[i] = trig;
              end else if ((c.now - deb_since[i]) >= 32'(cfg_debounce)) begin
                settled_lvl[i] = trig;
                deb_busy[i]    = 1'b0;
                note_state(i, trig ? azq_pkg::ST_TRIGGERED : azq_pkg::ST_NORMAL);
              end
            end else begin
              deb_busy[i] = 1'b0;
            end
          end
        end
      end
      // zone field cannot exceed the zone count, so no range check here
      azq_pkg::CMD_VIRT: begin
        if (c.level) begin
          virt_on[c.zone]    = 1'b1;
          virt_since[c.zone] = c.now;
        end else begin
          virt_on[c.zone] = 1'b0;
        end
      end
      azq_pkg::CMD_BYPASS: begin
        if (c.level) begin
          zone_state[c.zone] = azq_pkg::ST_BYPASSED;
        end else begin
          zone_state[c.zone]  = azq_pkg::ST_NORMAL;
          settled_lvl[c.zone] = 1'b0;
          deb_busy[c.zone]    = 1'b0;
        end
      end
      default: ;
    endcase

    // Closing summary
    w.kind      = azq_pkg::KIND_SUMMARY;
    w.all_clear = 1'b1;
    w.last      = 1'b1;
    for (int i = 0; i < ZONES; i++) begin
      if (zone_state[i] == azq_pkg::ST_TRIGGERED) w.trig_mask[i] = 1'b1;
      if (cfg_enabled[i] && zone_state[i] != azq_pkg::ST_BYPASSED &&
          zone_state[i] != azq_pkg::ST_NORMAL)
        w.all_clear = 1'b0;
    end
    expected_words.push_back(w);
  endfunction

  // Offer one command word; called at a rising edge, returns at its handshake
  task automatic push_command(zone_cmd_t c);
    if (send_gap > 0) repeat (send_gap) @(posedge clk_i);
    in_bus.valid        <= 1'b1;
    in_bus.command      <= c.cmd;
    in_bus.now_ms       <= c.now;
    in_bus.input_levels <= c.levels;
    in_bus.tamper       <= c.tamper;
    in_bus.zone         <= c.zone;
    in_bus.level        <= c.level;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    qualify_command(c);
    commands_sent++;
    // draw the gap before the next word; hold valid when there is none
    send_gap = no_idle ? 0 : $urandom_range(0, 3);
    if (send_gap > 0) in_bus.valid <= 1'b0;
  endtask

  // Drop valid right after a handshake, unless the gap draw already did
  task automatic stop_sending();
    if (send_gap == 0) in_bus.valid <= 1'b0;
    send_gap = 0;
  endtask

  // Pause the sender until every predicted word has arrived
  task automatic drain_results();
    stop_sending();
    while (expected_words.size() != 0) @(posedge clk_i);
  endtask

  // Write all four registers back to back; upper data bits carry noise
  task automatic write_registers(logic [15:0] en, logic [15:0] nc, logic [15:0] deb,
                                 logic [19:0] vto);
    logic [azq_pkg::CFG_IDX_W-1:0]  reg_idx [4];
    logic [azq_pkg::CFG_DATA_W-1:0] word;
    reg_idx = '{azq_pkg::CFG_ENABLED, azq_pkg::CFG_NC_WIRING, azq_pkg::CFG_DEBOUNCE,
                azq_pkg::CFG_VIRT_TMO};
    for (int r = 0; r < 4; r++) begin
      word = $urandom();
      case (reg_idx[r])
        azq_pkg::CFG_ENABLED:   word[15:0] = en;
        azq_pkg::CFG_NC_WIRING: word[15:0] = nc;
        azq_pkg::CFG_DEBOUNCE:  word[15:0] = deb;
        default:                word[19:0] = vto;
      endcase
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= reg_idx[r];
      cfg_bus.data  <= word;
      @(posedge clk_i);
      while (!cfg_bus.ready) @(posedge clk_i);
      case (reg_idx[r])
        azq_pkg::CFG_ENABLED:   cfg_enabled  = word[15:0];
        azq_pkg::CFG_NC_WIRING: cfg_nc       = word[15:0];
        azq_pkg::CFG_DEBOUNCE:  cfg_debounce = word[15:0];
        default:                cfg_virt_tmo = word[19:0];
      endcase
    end
    cfg_bus.valid <= 1'b0;
    settings_used++;
  endtask

  // Mostly scans of slowly changing levels, with set commands and noise mixed in
  task automatic send_random_command(int unsigned step_max);
    zone_cmd_t   c;
    int unsigned pick;
    pick     = $urandom_range(0, 99);
    wall_ms  = wall_ms + $urandom_range(0, step_max);
    c.now    = wall_ms;
    c.levels = 16'($urandom());
    c.tamper = 1'($urandom());
    c.zone   = 4'($urandom());
    c.level  = 1'($urandom());
    if (pick < 76) begin
      c.cmd = azq_pkg::CMD_SCAN;
      loop_levels ^= 16'($urandom() & $urandom() & $urandom());
      if (pick < 70) c.levels = loop_levels;
      c.tamper = ($urandom_range(0, 24) == 0);
    end else if (pick < 86) begin
      c.cmd = azq_pkg::CMD_VIRT;
    end else if (pick < 97) begin
      c.cmd   = azq_pkg::CMD_BYPASS;
      c.level = ($urandom_range(0, 9) < 4);
    end else begin
      c.cmd = CMD_UNUSED;
    end
    push_command(c);
  endtask

  task automatic run_phase(logic [15:0] en, logic [15:0] nc, logic [15:0] deb,
                           logic [19:0] vto, logic [31:0] t0, int unsigned step_max,
                           int count);
    drain_results();
    write_registers(en, nc, deb, vto);
    wall_ms     = t0;
    loop_levels = 16'($urandom());
    for (int k = 0; k < count; k++) send_random_command(step_max);
  endtask

  // Result receiver: random stalls, plus one long hold-off on request
  initial begin
    int gap;
    out_bus.ready <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (sink_hold > 0) begin
        gap       = sink_hold;
        sink_hold = 0;
      end
      if (gap > 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_bus.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_bus.valid) @(posedge clk_i);
    end
  end

  // Compare each accepted word against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      got.kind      = out_bus.kind;
      got.zone      = out_bus.event_zone;
      got.state     = azq_pkg::zstat_e'(out_bus.new_state);
      got.trig_mask = out_bus.triggered_mask;
      got.all_clear = out_bus.all_clear;
      got.last      = out_bus.last;
      if (got.kind == azq_pkg::KIND_SUMMARY) summaries_seen++;
      else events_seen++;
      if (expected_words.size() == 0) begin
        flag_error("unexpected word", '0, got);
      end else begin
        want = expected_words.pop_front();
        if (got.kind !== want.kind || got.zone !== want.zone || got.state !== want.state
            || got.trig_mask !== want.trig_mask || got.all_clear !== want.all_clear
            || got.last !== want.last)
          flag_error("mismatch", want, got);
      end
    end
  end

  // Stimulus
  initial begin
    zone_cmd_t   c;
    azq_word_t   known;
    int unsigned deb_pick;
    error_count    = 0;
    cycle_count    = 0;
    commands_sent  = 0;
    events_seen    = 0;
    summaries_seen = 0;
    settings_used  = 1;
    send_gap       = 0;
    sink_hold      = 0;
    no_idle        = 1'b0;
    wall_ms        = '0;
    loop_levels    = '0;
    clear_model();

    rst_ni              <= 1'b0;
    in_bus.valid        <= 1'b0;
    in_bus.command      <= azq_pkg::CMD_SCAN;
    in_bus.now_ms       <= '0;
    in_bus.input_levels <= '0;
    in_bus.tamper       <= 1'b0;
    in_bus.zone         <= '0;
    in_bus.level        <= 1'b0;
    cfg_bus.valid       <= 1'b0;
    cfg_bus.index       <= azq_pkg::CFG_ENABLED;
    cfg_bus.data        <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed table under reset register values
    for (int r = 0; r < NUM_DIRECTED; r++) begin
      c.cmd    = directed_rows[r].cmd;
      c.now    = directed_rows[r].now;
      c.levels = directed_rows[r].levels;
      c.tamper = directed_rows[r].tamper;
      c.zone   = directed_rows[r].zone;
      c.level  = directed_rows[r].level;
      push_command(c);
      if (directed_rows[r].known) begin
        known           = '0;
        known.kind      = azq_pkg::KIND_SUMMARY;
        known.trig_mask = directed_rows[r].known_mask;
        known.all_clear = directed_rows[r].known_clear;
        known.last      = 1'b1;
        expected_words[expected_words.size() - 1] = known;
      end
    end

    // Zero debounce and zero virtual lifetime, no idling on either side
    no_idle = 1'b1;
    run_phase(16'hFFFF, 16'h0000, 16'd0, 20'd0, $urandom(), 5, 30);
    no_idle = 1'b0;

    // Random masks; receiver holds off long enough to back up the input
    drain_results();
    sink_hold = LONG_HOLD;
    run_phase(16'($urandom()), 16'($urandom()), 16'd20, 20'd200, $urandom(), 15, 60);

    // Nothing enabled, then every zone normally closed at maximum times
    run_phase(16'h0000, 16'hFFFF, 16'hFFFF, 20'hFFFFF, 32'hFFFF_0000, 40000, 15);
    run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 20'hFFFFF, 32'hFFFF_8000, 40000, 40);

    // Mid-range random settings
    deb_pick = $urandom_range(1, 100);
    run_phase(16'($urandom() | $urandom()), 16'($urandom()), 16'(deb_pick),
              20'($urandom_range(50, 2000)), $urandom(), deb_pick / 2 + 3, 40);
    deb_pick = $urandom_range(1, 100);
    run_phase(16'($urandom() | $urandom()), 16'($urandom()), 16'(deb_pick),
              20'($urandom_range(50, 2000)), $urandom(), deb_pick / 2 + 3, 40);

    // Wind down and let any stray word show up
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_words.size() != 0) begin
      error_count++;
      $display("alarm_zone_input_qualifier_test: %0d predicted words never arrived",
               expected_words.size());
    end

    $display("alarm_zone_input_qualifier_test: %0d commands, %0d events, %0d summaries",
             commands_sent, events_seen, summaries_seen);
    $display("alarm_zone_input_qualifier_test: %0d register sets, %0d failures",
             settings_used, error_count);
    if (error_count == 0) begin
      $display("alarm_zone_input_qualifier_test: done, clean");
    end else begin
      $display("alarm_zone_input_qualifier_test: done, errors");
    end
    $finish;
  end

endmodule
